### rtl/lpwt_pkg.sv
// Shared constants, codes and controller/datapath interface types for the word table.
package lpwt_pkg;

    localparam int SLOTS           = 26;
    localparam int SLOT_W          = 5;
    localparam int LETTER_W        = 5;
    localparam int OP_W            = 2;
    localparam int WORD_W          = 60;
    localparam int OUTCOME_W       = 3;
    localparam int MAX_LETTERS_DEF = 12;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_INSERTED  = 3'd0,
        OUT_DUPLICATE = 3'd1,
        OUT_FULL      = 3'd2,
        OUT_DELETED   = 3'd3,
        OUT_NOT_FOUND = 3'd4,
        OUT_READ      = 3'd5
    } outcome_t;

    // Controller to datapath
    typedef struct packed {
        logic     load_in;    // capture the request
        logic     rd_idx;     // read the addressed slot
        logic     rd_scan;    // read the probe slot, advance probe pointer
        logic     next_chk;   // count one probed slot as checked
        logic     take_hit;   // commit the hit found in the checked slot
        logic     set_fail;   // record a failure result
        outcome_t fail_code;
        logic     set_read;   // record the slot read result
        logic     load_out;   // move the result into the output register
    } lpwt_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            home_ok;
        logic            home_occ;
        logic            hit;
        logic            last_chk;
        logic            out_free;
    } lpwt_status_t;

endpackage

### rtl/lpwt_ctrl.sv
// Request sequencer for the word table: classify, probe, and hand off results.
module lpwt_ctrl
    import lpwt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  lpwt_status_t st,
    output lpwt_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_START  = 5'b00010,
        S_SCAN   = 5'b00100,
        S_RDWAIT = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_START;
                end
            end
            S_START:
            begin
                case (st.op)
                    OP_READ:
                    begin
                        cmd.rd_idx = 1'b1;
                        state_next = S_RDWAIT;
                    end
                    OP_INSERT:
                    begin
                        if (st.home_ok)
                        begin
                            cmd.rd_scan = 1'b1;
                            state_next  = S_SCAN;
                        end
                        else
                        begin
                            cmd.set_fail  = 1'b1;
                            cmd.fail_code = OUT_FULL;
                            state_next    = S_DONE;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (st.home_ok && st.home_occ)
                        begin
                            cmd.rd_scan = 1'b1;
                            state_next  = S_SCAN;
                        end
                        else
                        begin
                            cmd.set_fail  = 1'b1;
                            cmd.fail_code = OUT_NOT_FOUND;
                            state_next    = S_DONE;
                        end
                    end
                    default:
                    begin
                        cmd.set_fail  = 1'b1;
                        cmd.fail_code = OUT_NOT_FOUND;
                        state_next    = S_DONE;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (st.hit)
                begin
                    cmd.take_hit = 1'b1;
                    state_next   = S_DONE;
                end
                else if (st.last_chk)
                begin
                    cmd.set_fail  = 1'b1;
                    cmd.fail_code = (st.op == OP_INSERT) ? OUT_FULL : OUT_NOT_FOUND;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.rd_scan  = 1'b1;
                    cmd.next_chk = 1'b1;
                end
            end
            S_RDWAIT:
            begin
                cmd.set_read = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_load_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> st.out_free)
        else $error("result moved into a busy output register");

    a_scan_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> ($past(state_reg) == S_START || $past(state_reg) == S_SCAN))
        else $error("probe scan entered without a start step");
`endif

endmodule

### rtl/lpwt_dp.sv
// Datapath for the word table: slot memory, occupancy flags, probe pointer, result registers.
module lpwt_dp
    import lpwt_pkg::*;
#(
    parameter int MAX_LETTERS = MAX_LETTERS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lpwt_cmd_t            cmd,
    output lpwt_status_t         st,
    input  logic [OP_W-1:0]      operation,
    input  logic [WORD_W-1:0]    word,
    input  logic [SLOT_W-1:0]    slot_index,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [OUTCOME_W-1:0] outcome,
    output logic [SLOT_W-1:0]    slot,
    output logic                 slot_occupied,
    output logic [WORD_W-1:0]    slot_word
);

    localparam int WORD_BITS = LETTER_W * MAX_LETTERS;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    logic [OP_W-1:0]      op_reg;
    logic [WORD_BITS-1:0] word_reg;
    logic [SLOT_W-1:0]    idx_reg;
    logic [SLOT_W-1:0]    pos_reg;
    logic [SLOT_W-1:0]    chk_reg;
    logic [SLOT_W-1:0]    cnt_reg;
    logic [SLOTS-1:0]     flags_reg;
    logic [WORD_BITS-1:0] rdata_reg;
    logic [WORD_BITS-1:0] mem [SLOTS];

    outcome_t             res_outcome_reg;
    logic [SLOT_W-1:0]    res_slot_reg;
    logic                 res_occ_reg;
    logic [WORD_BITS-1:0] res_word_reg;

    logic                 out_valid_reg;
    outcome_t             out_outcome_reg;
    logic [SLOT_W-1:0]    out_slot_reg;
    logic                 out_occ_reg;
    logic [WORD_W-1:0]    out_word_reg;

    logic [LETTER_W-1:0]  last_letter;
    logic                 home_ok;
    logic                 idx_ok;
    logic                 flag_chk;
    logic                 flag_idx;
    logic                 word_eq;
    logic                 hit_ins;
    logic                 hit_dup;
    logic                 hit_del;
    logic                 rd_en;
    logic [SLOT_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [SLOT_W-1:0]    pos_adv;
    logic [WORD_W-1:0]    word_ext;

    assign last_letter = word_reg[LETTER_W-1:0];
    assign home_ok     = (last_letter != '0) && (last_letter <= SLOT_W'(SLOTS));
    assign idx_ok      = (idx_reg < SLOT_W'(SLOTS));
    assign flag_chk    = (chk_reg < SLOT_W'(SLOTS)) ? flags_reg[chk_reg] : 1'b0;
    assign flag_idx    = idx_ok ? flags_reg[idx_reg] : 1'b0;
    assign word_eq     = (rdata_reg == word_reg);

    assign hit_ins = (op_reg == OP_INSERT) && !flag_chk;
    assign hit_dup = (op_reg == OP_INSERT) && flag_chk && word_eq;
    assign hit_del = (op_reg == OP_DELETE) && flag_chk && word_eq;

    assign pos_adv = (pos_reg == LAST_SLOT) ? '0 : pos_reg + 1'b1;

    assign rd_en   = cmd.rd_scan || (cmd.rd_idx && idx_ok);
    assign rd_addr = cmd.rd_scan ? pos_reg : idx_reg;
    assign wr_en   = cmd.take_hit && hit_ins;

    always_comb
    begin
        st.op       = op_reg;
        st.home_ok  = home_ok;
        st.home_occ = home_ok && (pos_reg < SLOT_W'(SLOTS)) && flags_reg[pos_reg];
        st.hit      = hit_ins || hit_dup || hit_del;
        st.last_chk = (cnt_reg == LAST_SLOT);
        st.out_free = !out_valid_reg || out_ready;
    end

    // Slot memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[chk_reg] <= word_reg;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Request capture and probe pointer; home slot is last letter minus one
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg   <= operation;
            word_reg <= word[WORD_BITS-1:0];
            idx_reg  <= slot_index;
            pos_reg  <= word[LETTER_W-1:0] - 1'b1;
        end
        else if (cmd.rd_scan)
        begin
            chk_reg <= pos_reg;
            pos_reg <= pos_adv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                flags_reg[chk_reg] <= 1'b1;
            end
            else if (cmd.take_hit && hit_del)
            begin
                flags_reg[chk_reg] <= 1'b0;
            end
            if (cmd.load_in)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.next_chk)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Pending result
    always_ff @(posedge clk)
    begin
        if (cmd.set_fail)
        begin
            res_outcome_reg <= cmd.fail_code;
            res_slot_reg    <= '0;
            res_occ_reg     <= 1'b0;
            res_word_reg    <= '0;
        end
        else if (cmd.set_read)
        begin
            res_outcome_reg <= OUT_READ;
            res_slot_reg    <= idx_reg;
            res_occ_reg     <= flag_idx;
            res_word_reg    <= flag_idx ? rdata_reg : '0;
        end
        else if (cmd.take_hit)
        begin
            res_outcome_reg <= hit_ins ? OUT_INSERTED : (hit_dup ? OUT_DUPLICATE : OUT_DELETED);
            res_slot_reg    <= hit_dup ? '0 : chk_reg;
            res_occ_reg     <= 1'b0;
            res_word_reg    <= '0;
        end
    end

    always_comb
    begin
        word_ext                 = '0;
        word_ext[WORD_BITS-1:0] = res_word_reg;
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_outcome_reg <= res_outcome_reg;
            out_slot_reg    <= res_slot_reg;
            out_occ_reg     <= res_occ_reg;
            out_word_reg    <= word_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign outcome       = out_outcome_reg;
    assign slot          = out_slot_reg;
    assign slot_occupied = out_occ_reg;
    assign slot_word     = out_word_reg;

`ifndef SYNTHESIS
    a_insert_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> flags_reg[$past(chk_reg)])
        else $error("inserted slot not marked occupied");

    a_probe_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < SLOT_W'(SLOTS))
        else $error("probe count ran past the table size");
`endif

endmodule

### rtl/linear_probe_word_table.sv
// Top level of the 26-slot linearly probed word table.
//
//  channel   handshake              payload
//  --------  ---------------------  ---------------------------------------
//  request   in_valid / in_ready    operation, word, slot_index
//  result    out_valid / out_ready  outcome, slot, slot_occupied, slot_word
//
// Flow: one request at a time. Insert and delete probe n (1..26) slots, one
// slot memory read per cycle, before the result step; a read looks only at
// the addressed slot, and requests rejected at classification probe none.
// Reset: clears the occupancy flags at once; the slot memory is not cleared,
// as a slot is only looked at while its flag is set.
// Stalls: the result register holds a finished result while the next request
// is accepted and processed; a request waits in its final step until the
// result register is free.
module linear_probe_word_table
    import lpwt_pkg::*;
#(
    parameter int MAX_LETTERS = MAX_LETTERS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [OP_W-1:0]      operation,
    input  logic [WORD_W-1:0]    word,
    input  logic [SLOT_W-1:0]    slot_index,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [OUTCOME_W-1:0] outcome,
    output logic [SLOT_W-1:0]    slot,
    output logic                 slot_occupied,
    output logic [WORD_W-1:0]    slot_word
);

    lpwt_cmd_t    cmd;
    lpwt_status_t st;

    // Sequencer: accepts a request, steps the probe, hands off the result
    lpwt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    // Slot memory, flags, probe pointer and result registers
    lpwt_dp #(
        .MAX_LETTERS (MAX_LETTERS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .operation     (operation),
        .word          (word),
        .slot_index    (slot_index),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .outcome       (outcome),
        .slot          (slot),
        .slot_occupied (slot_occupied),
        .slot_word     (slot_word)
    );

endmodule
